>>> design/job_dispatcher_fastest_idle_worker_defines.svh
// ----------------------------------------------------------------------------
// job dispatcher assertion macros
// shared concurrent assertion helpers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef JOB_DISPATCHER_FASTEST_IDLE_WORKER_DEFINES_SVH
`define JOB_DISPATCHER_FASTEST_IDLE_WORKER_DEFINES_SVH

// property must hold at every clock edge out of reset
`define JDFW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen
`define JDFW_NEVER(name, expr, msg) \
  `JDFW_ASSERT(name, !(expr), msg)

`endif

>>> design/jdfw_pkg.sv
// ----------------------------------------------------------------------------
// jdfw_pkg
// shared types and constants of the job dispatcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jdfw_pkg;

  localparam int MAX_WORKERS     = 4;
  localparam int WIDX_W          = 2;
  localparam int ID_W            = 16;
  localparam int LINES_W         = 10;
  localparam int COST_W          = 4;
  localparam int PROD_W          = COST_W + LINES_W;
  localparam int TICK_W          = 32;
  localparam int KIND_W          = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 4;
  localparam int IN_TDATA_W      = 32;
  localparam int OUT_TDATA_W     = 56;
  localparam int JOB_W           = ID_W + LINES_W;
  localparam int DEF_NUM_WORKERS = 3;
  localparam int DEF_QUEUE_DEPTH = 128;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COST_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd4;

  localparam logic [COST_W-1:0]      COST_RESET   = 4'd1;
  localparam logic [MAX_WORKERS-1:0] ENABLE_RESET = 4'hf;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_DROP    = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DISP_RD,
    ST_DISP_SEL,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic              found;
    logic [WIDX_W-1:0] idx;
  } pick_t;

endpackage

>>> design/job_dispatcher_fastest_idle_worker.sv
// ----------------------------------------------------------------------------
// job_dispatcher_fastest_idle_worker
// fifo of jobs in ram, handed to the cheapest idle enabled worker
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid / tready        | tuser req_type, tdata id, lines
//  m_axis    | out       | tvalid / tready        | tuser kind, tdata widx, id, ticks, tlast
//  cfg       | in        | cfg_we_i, no wait      | cfg_addr_i, cfg_wdata_i
//
// after accept: an enqueue writes the queue ram and then dispatches jobs, a drop goes straight to the result
// tick: scans each of the NUM_WORKERS workers in turn, then dispatches jobs, then gives the summary
// each dispatch is a read of the queue ram head, then a worker pick
// results stall on m_axis tready, the output register frees the input side
// reset empties the queue and idles all workers, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module job_dispatcher_fastest_idle_worker #(
  parameter int NUM_WORKERS = jdfw_pkg::DEF_NUM_WORKERS,
  parameter int QUEUE_DEPTH = jdfw_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: job_id [15:0], line_count [25:16], zero [31:26]
  input  logic [jdfw_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // tuser: req_type [0]
  input  logic                                s_axis_tuser_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: worker_index [1:0], done_job_id [17:2], elapsed_ticks [49:18], zero [55:50]
  output logic [jdfw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // tuser: result_kind [1:0]
  output logic [jdfw_pkg::KIND_W-1:0]         m_axis_tuser_o,
  output logic                                m_axis_tlast_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_we_i,
  input  logic [jdfw_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [jdfw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

`include "job_dispatcher_fastest_idle_worker_defines.svh"

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int MW     = jdfw_pkg::MAX_WORKERS;
  localparam logic [MW-1:0] WMASK = MW'((1 << NUM_WORKERS) - 1);
  localparam logic [jdfw_pkg::WIDX_W-1:0] LAST_W = jdfw_pkg::WIDX_W'(NUM_WORKERS - 1);

  jdfw_pkg::state_e state_q, state_d;

  logic [jdfw_pkg::WIDX_W-1:0]                        w_q;
  logic [PTR_W-1:0]                                   head_q;
  logic [FILL_W-1:0]                                  fill_q;
  logic [MW-1:0]                                      busy_q;
  logic [MW-1:0][jdfw_pkg::ID_W-1:0]                  wid_q;
  logic [MW-1:0][jdfw_pkg::LINES_W-1:0]               wlines_q;
  logic [jdfw_pkg::TICK_W-1:0]                        tick_q;
  logic [MW-1:0][jdfw_pkg::COST_W-1:0]                cost_q;
  logic [MW-1:0]                                      en_q;
  jdfw_pkg::kind_e                                    fin_kind_q;
  logic [jdfw_pkg::ID_W-1:0]                          fin_id_q;

  logic                          out_valid_q;
  jdfw_pkg::kind_e               out_kind_q;
  logic [jdfw_pkg::WIDX_W-1:0]   out_widx_q;
  logic [jdfw_pkg::ID_W-1:0]     out_id_q;
  logic [jdfw_pkg::TICK_W-1:0]   out_tick_q;
  logic                          out_last_q;

  logic                          in_acc;
  logic                          req_tick;
  logic [jdfw_pkg::ID_W-1:0]     in_id;
  logic [jdfw_pkg::LINES_W-1:0]  in_lines;
  logic                          full;
  logic [MW-1:0]                 en_eff;
  logic [MW-1:0]                 idle_en;
  logic                          progress;
  logic [SUM_W-1:0]              tail_sum;
  logic [PTR_W-1:0]              tail;
  logic [PTR_W-1:0]              head_nxt;
  logic                          out_free;
  logic                          scan_act;
  logic                          scan_fin;
  logic                          scan_go;
  logic                          ram_we;
  logic                          ram_re;
  logic                          disp_take;
  logic                          fin_emit;
  logic [jdfw_pkg::JOB_W-1:0]    ram_rdata;
  logic [jdfw_pkg::LINES_W-1:0]  rd_lines;
  jdfw_pkg::pick_t               pick;

  assign req_tick = s_axis_tuser_i;
  assign in_id    = s_axis_tdata_i[jdfw_pkg::ID_W-1:0];
  assign in_lines = s_axis_tdata_i[jdfw_pkg::ID_W +: jdfw_pkg::LINES_W];
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == jdfw_pkg::ST_IDLE);

  assign full     = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign en_eff   = en_q & WMASK;
  assign idle_en  = ~busy_q & en_eff;
  assign progress = |(busy_q & en_eff);
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[PTR_W-1:0];
  end

  assign head_nxt = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  assign scan_act = en_eff[w_q] && busy_q[w_q];
  assign scan_fin = scan_act && (wlines_q[w_q] <= jdfw_pkg::LINES_W'(1));
  assign rd_lines = ram_rdata[jdfw_pkg::ID_W +: jdfw_pkg::LINES_W];

  jdfw_ram #(
    .WIDTH (jdfw_pkg::JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail),
    .wdata_i ({in_lines, in_id}),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  jdfw_pick u_pick (
    .cost_i  (cost_q),
    .idle_i  (idle_en),
    .lines_i (rd_lines),
    .pick_o  (pick)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jdfw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (req_tick) begin
            state_d = jdfw_pkg::ST_SCAN;
          end else if (full) begin
            state_d = jdfw_pkg::ST_FINAL;
          end else begin
            state_d = jdfw_pkg::ST_DISP_RD;
          end
        end
      end
      jdfw_pkg::ST_SCAN: begin
        if (scan_go && w_q == LAST_W) begin
          state_d = jdfw_pkg::ST_DISP_RD;
        end
      end
      jdfw_pkg::ST_DISP_RD: begin
        if (fill_q != '0 && idle_en != '0) begin
          state_d = jdfw_pkg::ST_DISP_SEL;
        end else begin
          state_d = jdfw_pkg::ST_FINAL;
        end
      end
      jdfw_pkg::ST_DISP_SEL: begin
        state_d = jdfw_pkg::ST_DISP_RD;
      end
      jdfw_pkg::ST_FINAL: begin
        if (out_free) begin
          state_d = jdfw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = jdfw_pkg::ST_IDLE;
      end
    endcase
  end

  // control strobes
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    scan_go   = 1'b0;
    disp_take = 1'b0;
    fin_emit  = 1'b0;
    case (state_q)
      jdfw_pkg::ST_IDLE: begin
        ram_we = in_acc && !req_tick && !full;
      end
      jdfw_pkg::ST_SCAN: begin
        scan_go = !scan_fin || out_free;
      end
      jdfw_pkg::ST_DISP_RD: begin
        ram_re = (fill_q != '0) && (idle_en != '0);
      end
      jdfw_pkg::ST_DISP_SEL: begin
        disp_take = pick.found;
      end
      jdfw_pkg::ST_FINAL: begin
        fin_emit = out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jdfw_pkg::ST_IDLE;
      w_q         <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      busy_q      <= '0;
      tick_q      <= '0;
      cost_q      <= {MW{jdfw_pkg::COST_RESET}};
      en_q        <= jdfw_pkg::ENABLE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_addr_i)
          jdfw_pkg::CFG_COST_0: cost_q[0] <= cfg_wdata_i;
          jdfw_pkg::CFG_COST_1: cost_q[1] <= cfg_wdata_i;
          jdfw_pkg::CFG_COST_2: cost_q[2] <= cfg_wdata_i;
          jdfw_pkg::CFG_COST_3: cost_q[3] <= cfg_wdata_i;
          jdfw_pkg::CFG_ENABLE: en_q      <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_acc) begin
        w_q <= '0;
        if (req_tick && progress) begin
          tick_q <= tick_q + 1'b1;
        end
      end
      if (ram_we) begin
        fill_q <= fill_q + 1'b1;
      end

      if (scan_go) begin
        w_q <= w_q + 1'b1;
        if (scan_fin) begin
          busy_q[w_q] <= 1'b0;
        end
      end

      if (disp_take) begin
        busy_q[pick.idx] <= 1'b1;
        head_q           <= head_nxt;
        fill_q           <= fill_q - 1'b1;
      end

      if ((scan_go && scan_fin) || fin_emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fin_id_q <= req_tick ? '0 : in_id;
      if (req_tick) begin
        fin_kind_q <= jdfw_pkg::KIND_SUMMARY;
      end else if (full) begin
        fin_kind_q <= jdfw_pkg::KIND_DROP;
      end else begin
        fin_kind_q <= jdfw_pkg::KIND_ACCEPT;
      end
    end
    if (scan_go && scan_act && wlines_q[w_q] != '0) begin
      wlines_q[w_q] <= wlines_q[w_q] - 1'b1;
    end
    if (disp_take) begin
      wid_q[pick.idx]    <= ram_rdata[jdfw_pkg::ID_W-1:0];
      wlines_q[pick.idx] <= rd_lines;
    end
    if (scan_go && scan_fin) begin
      out_kind_q <= jdfw_pkg::KIND_DONE;
      out_widx_q <= w_q;
      out_id_q   <= wid_q[w_q];
      out_tick_q <= tick_q;
      out_last_q <= 1'b0;
    end else if (fin_emit) begin
      out_kind_q <= fin_kind_q;
      out_widx_q <= '0;
      out_id_q   <= fin_id_q;
      out_tick_q <= tick_q;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {{(jdfw_pkg::OUT_TDATA_W - jdfw_pkg::TICK_W - jdfw_pkg::ID_W
                              - jdfw_pkg::WIDX_W){1'b0}},
                            out_tick_q, out_id_q, out_widx_q};

  `JDFW_ASSERT(a_fill_bound, fill_q <= FILL_W'(QUEUE_DEPTH), "queue fill beyond depth")
  `JDFW_ASSERT(a_head_bound, head_q <= PTR_W'(QUEUE_DEPTH - 1), "queue head out of range")
  `JDFW_NEVER(a_busy_unused, (busy_q & ~WMASK) != '0, "worker beyond count marked busy")
  `JDFW_NEVER(a_done_last, m_axis_tvalid_o && m_axis_tlast_o && m_axis_tuser_o == jdfw_pkg::KIND_DONE, "finished job item marked last")

endmodule

>>> design/jdfw_ram.sv
// ----------------------------------------------------------------------------
// jdfw_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/jdfw_pick.sv
// ----------------------------------------------------------------------------
// jdfw_pick
// picks the idle enabled worker with the smallest cost times lines
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdfw_pick (
  input  logic [jdfw_pkg::MAX_WORKERS-1:0][jdfw_pkg::COST_W-1:0] cost_i,
  input  logic [jdfw_pkg::MAX_WORKERS-1:0]                       idle_i,
  input  logic [jdfw_pkg::LINES_W-1:0]                           lines_i,
  output jdfw_pkg::pick_t                                        pick_o
);

  logic [jdfw_pkg::MAX_WORKERS-1:0][jdfw_pkg::PROD_W-1:0] prod;

  always_comb begin
    for (int i = 0; i < jdfw_pkg::MAX_WORKERS; i++) begin
      prod[i] = jdfw_pkg::PROD_W'(cost_i[i]) * jdfw_pkg::PROD_W'(lines_i);
    end
  end

  // ties keep the lower index
  always_comb begin
    logic [jdfw_pkg::PROD_W-1:0] best;
    best         = '0;
    pick_o.found = 1'b0;
    pick_o.idx   = '0;
    for (int i = 0; i < jdfw_pkg::MAX_WORKERS; i++) begin
      if (idle_i[i] && (!pick_o.found || prod[i] < best)) begin
        pick_o.found = 1'b1;
        pick_o.idx   = jdfw_pkg::WIDX_W'(i);
        best         = prod[i];
      end
    end
  end

endmodule
